// ----- sv/mrtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum radix token converter package
// Shared widths, character codes, payload types and the digit decoder.
// ----------------------------------------------------------------------------
package mrtc_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W    = 6;
    localparam int VALUE_W    = 31;
    localparam int PROD_W     = VALUE_W + DIGIT_W;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_Z_LOWER = 8'h7A;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_Z_UPPER = 8'h5A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic               is_number;
        logic [DIGIT_W-1:0] min_base;
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    typedef struct packed {
        logic take;
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic done;
        logic out_free;
    } t_status;

    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit d;
        d.ok  = 1'b1;
        d.val = '0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d.val = DIGIT_W'(ch - CH_0);
        end else if (ch >= CH_A_LOWER && ch <= CH_Z_LOWER) begin
            d.val = DIGIT_W'(ch - CH_A_LOWER) + DIGIT_TEN;
        end else if (ch >= CH_A_UPPER && ch <= CH_Z_UPPER) begin
            d.val = DIGIT_W'(ch - CH_A_UPPER) + DIGIT_TEN;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/mrtc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum radix token converter controller
// Sequences collection of bytes and the Horner evaluation of a closed token.
// ----------------------------------------------------------------------------
module mrtc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  mrtc_pkg::t_status     i_status,
    output mrtc_pkg::t_cmd        o_cmd
);
    import mrtc_pkg::*;

    localparam logic S_COLLECT = 1'b0;
    localparam logic S_EVAL    = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        o_in_stall  = (r_state != S_COLLECT);
        unique case (r_state)
            S_COLLECT: begin
                o_cmd.take  = i_in_valid;
                o_cmd.start = i_in_valid && i_status.close;
                if (o_cmd.start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.step = 1'b1;
                o_cmd.load = i_status.done && i_status.out_free;
                if (o_cmd.load) begin
                    n_state = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- sv/mrtc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum radix token converter datapath
// Token tracking, digit store, Horner multiply-add and the result register.
// ----------------------------------------------------------------------------
module mrtc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  mrtc_pkg::t_in_item       i_in_data,
    input  mrtc_pkg::t_cmd           i_cmd,
    output mrtc_pkg::t_status        o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mrtc_pkg::t_out_item      o_out_data
);
    import mrtc_pkg::*;

    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_data;

    logic [LEN_W-1:0]   r_len;
    logic [DIGIT_W-1:0] r_max;
    logic               r_in_token;
    logic               r_bad;
    logic               r_too_long;

    logic [LEN_W-1:0]   r_cnt;
    logic               r_rd_vld;
    logic [VALUE_W-1:0] r_acc;
    logic               r_sat;
    logic               r_out_vld;
    t_out_item          r_out;

    t_digit             w_dig;
    logic               w_sep;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic               w_issue;
    logic [DIGIT_W-1:0] w_radix;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W:0]    w_sum;

    assign w_dig   = digit_of(i_in_data.char_code);
    assign w_sep   = (i_in_data.char_code == CH_SPACE) || (i_in_data.char_code == CH_TAB)
                     || (i_in_data.char_code == CH_LF);
    assign w_radix = r_max + DIGIT_W'(1);
    assign w_prod  = {{DIGIT_W{1'b0}}, r_acc} * {{VALUE_W{1'b0}}, w_radix};
    assign w_sum   = {1'b0, w_prod} + (PROD_W + 1)'(r_rd_data);
    assign w_issue = (r_cnt < r_len) && !r_sat && !r_bad;

    assign o_status.close    = r_in_token && (i_in_data.end_of_input || w_sep);
    assign o_status.done     = !w_issue && !r_rd_vld;
    assign o_status.out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_len[IDX_W-1:0];
        if (i_cmd.take && !i_in_data.end_of_input && w_dig.ok) begin
            if (!r_in_token) begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
            end else if (!w_sep && r_len < LEN_W'(MAX_DIGITS)) begin
                w_wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_dig.val;
        end
        r_rd_data <= r_store[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_max      <= '0;
            r_in_token <= 1'b0;
            r_bad      <= 1'b0;
            r_too_long <= 1'b0;
        end else if (i_cmd.take) begin
            if (o_status.close) begin
                r_in_token <= 1'b0;
            end else if (!i_in_data.end_of_input) begin
                if (!r_in_token) begin
                    if (w_dig.ok) begin
                        r_in_token <= 1'b1;
                        r_len      <= LEN_W'(1);
                        r_max      <= w_dig.val;
                        r_bad      <= 1'b0;
                        r_too_long <= 1'b0;
                    end
                end else if (!w_dig.ok) begin
                    r_bad <= 1'b1;
                end else begin
                    if (w_dig.val > r_max) begin
                        r_max <= w_dig.val;
                    end
                    if (r_len < LEN_W'(MAX_DIGITS)) begin
                        r_len <= r_len + LEN_W'(1);
                    end else begin
                        r_too_long <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_acc    <= '0;
            r_sat    <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_acc    <= '0;
            r_sat    <= r_too_long;
        end else if (i_cmd.step) begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_cnt <= r_cnt + LEN_W'(1);
            end
            if (r_rd_vld && !r_sat) begin
                if (w_sum > (PROD_W + 1)'(VALUE_MAX)) begin
                    r_sat <= 1'b1;
                end else begin
                    r_acc <= w_sum[VALUE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (r_bad) begin
                r_out <= '0;
            end else begin
                r_out.is_number <= 1'b1;
                r_out.min_base  <= w_radix;
                r_out.value     <= r_sat ? VALUE_MAX : r_acc;
                r_out.overflow  <= r_sat;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- sv/min_radix_token_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum radix token converter
// Splits a byte stream into tokens and reports, for each token, the smallest
// radix it reads in and its saturated value in that radix.
// ----------------------------------------------------------------------------
// Bytes inside a token are taken one per cycle. A closing transfer stalls the
// input while the Horner unit reads one stored digit per cycle; a broken or
// overlong token reads no digits, and the result waits while the previous
// result is still held. The result is registered and appears in the cycle
// after evaluation ends.
// Reset is synchronous and active low; it closes any open token and empties
// the result register. The digit store is not cleared.
// ----------------------------------------------------------------------------
module min_radix_token_converter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  mrtc_pkg::t_in_item       i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mrtc_pkg::t_out_item      o_out_data
);
    import mrtc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mrtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mrtc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (w_status.done && w_status.out_free))
        else $error("Result loaded before evaluation finished or while the output was full.");

    a_start_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> (w_cmd.take && !o_in_stall))
        else $error("Evaluation started without a closing transfer.");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_out_valid)
        else $error("Loaded result not presented on the output.");

    a_no_take_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_cmd.take)
        else $error("Input transfer taken during evaluation.");

endmodule
`default_nettype wire
